@@ src/ile_pkg.sv @@
// ile_pkg: shared types and codes for the indexed list engine.
// Used by ile_cell, ile_reduce and indexed_list_engine. No dependencies.
package ile_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_SWAP   = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_READ   = 3'd4
  } req_kind_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_TAG,
    S_DONE
  } ctl_state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    req_kind_t kind;
    logic      commit;
  } cell_ctrl_t;

endpackage

@@ src/indexed_list_engine.sv @@
// indexed_list_engine: ordered word list held in a chain of ile_cell slots.
// Depends on ile_pkg, ile_cell and ile_reduce.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | req_type, index_a, index_b, value
//   out_    | output    | out_valid/out_stall| status, found_index, read_value, count
//
// A request passes through S_TAG, in which every cell tags itself against it,
// and S_DONE, in which the buses and first-match encoder settle and the chain
// commits. The next request is accepted on the commit edge, not before. Reset
// clears the count and the handshake state; cell contents are left as they are.
// A stalled output holds the commit, and with it the input.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [REQ_W-1:0]                    in_req_type,
  input  logic [$clog2(DEPTH+1)-1:0]          in_index_a,
  input  logic [$clog2(DEPTH)-1:0]            in_index_b,
  input  logic signed [DATA_W-1:0]            in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [STAT_W-1:0]                   out_status,
  output logic [$clog2(DEPTH+1)-1:0]          out_found_index,
  output logic signed [DATA_W-1:0]            out_read_value,
  output logic [$clog2(DEPTH+1)-1:0]          out_count
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int BW = $clog2(DEPTH);
  localparam logic [IW-1:0] FULL_CNT = IW'(DEPTH);

  ctl_state_t        state_r, state_nxt;
  logic [REQ_W-1:0]  type_r;
  logic [IW-1:0]     ia_r;
  logic [BW-1:0]     ib_r;
  logic [DATA_W-1:0] value_r;
  logic [IW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r;
  logic [IW-1:0]     found_r;
  logic [DATA_W-1:0] rd_r;

  logic              in_fire, commit;
  status_t           status_c;
  logic [IW-1:0]     found_c;
  logic [DATA_W-1:0] rd_c;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] sel_a     [DEPTH];
  logic [DATA_W-1:0] sel_b     [DEPTH];
  logic              match     [DEPTH];
  logic [DATA_W-1:0] bus_a, bus_b;
  logic [IW-1:0]     first_idx;
  logic              any_match;

  // handshake
  assign commit   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == S_IDLE) || commit);
  assign in_fire  = in_valid && !in_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    priority if (in_fire) begin
      state_nxt = S_TAG;
    end else if (state_r == S_TAG) begin
      state_nxt = S_DONE;
    end else if (commit) begin
      state_nxt = S_IDLE;
    end else begin
      state_nxt = state_r;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      type_r  <= in_req_type;
      ia_r    <= in_index_a;
      ib_r    <= in_index_b;
      value_r <= in_value;
    end
  end

  // result and new count
  always_comb begin
    status_c  = ST_OK;
    found_c   = '0;
    rd_c      = '0;
    count_nxt = count_r;
    unique case (type_r)
      REQ_INSERT: begin
        if (ia_r > count_r) status_c = ST_BAD_INDEX;
        else if (count_r == FULL_CNT) status_c = ST_FULL;
        else count_nxt = count_r + IW'(1);
      end
      REQ_DELETE: begin
        if (ia_r >= count_r) status_c = ST_BAD_INDEX;
        else count_nxt = count_r - IW'(1);
      end
      REQ_SWAP: begin
        if ((ia_r >= count_r) || (IW'(ib_r) >= count_r)) status_c = ST_BAD_INDEX;
      end
      REQ_FIND: begin
        if (any_match) begin
          found_c = first_idx;
        end else begin
          found_c  = count_r;
          status_c = ST_NOT_FOUND;
        end
      end
      REQ_READ: begin
        if (ia_r >= count_r) status_c = ST_BAD_INDEX;
        else rd_c = bus_a;
      end
      default: status_c = ST_BAD_INDEX;
    endcase
  end

  // chain control: only a clean request changes the cells
  assign ctrl.kind   = req_kind_t'(type_r);
  assign ctrl.commit = commit && (status_c == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= status_c;
      found_r  <= found_c;
      rd_r     <= rd_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_index = found_r;
  assign out_read_value  = $signed(rd_r);
  assign out_count       = count_r;

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = cell_data[g];
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    ile_cell #(
      .IDX (g),
      .IW  (IW),
      .BW  (BW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx_a      (ia_r),
      .idx_b      (ib_r),
      .cnt        (count_r),
      .value      (value_r),
      .left_data  (left_d),
      .right_data (right_d),
      .bus_a      (bus_a),
      .bus_b      (bus_b),
      .data       (cell_data[g]),
      .sel_a      (sel_a[g]),
      .sel_b      (sel_b[g]),
      .match      (match[g])
    );
  end

  ile_reduce #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_reduce (
    .sel_a     (sel_a),
    .sel_b     (sel_b),
    .match     (match),
    .bus_a     (bus_a),
    .bus_b     (bus_b),
    .first_idx (first_idx),
    .any_match (any_match)
  );

endmodule

@@ src/ile_cell.sv @@
// ile_cell: one list slot. Holds a word, tags itself against the request and
// on commit shifts with its neighbors or swaps via the buses. Depends on ile_pkg.
module ile_cell
  import ile_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 7,
  parameter int BW  = 6
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [IW-1:0]     idx_a,
  input  logic [BW-1:0]     idx_b,
  input  logic [IW-1:0]     cnt,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] bus_a,
  input  logic [DATA_W-1:0] bus_b,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] sel_a,
  output logic [DATA_W-1:0] sel_b,
  output logic              match
);

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [BW-1:0] MY_IDX_B = BW'(IDX);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic [DATA_W-1:0] sel_a_r, sel_b_r;
  logic              match_r;
  logic              hit_a, hit_b;

  assign hit_a = (idx_a == MY_IDX);
  assign hit_b = (idx_b == MY_IDX_B);

  // tag stage: masked taps for the read buses and the value compare
  always_ff @(posedge clk) begin
    sel_a_r <= hit_a ? data_r : '0;
    sel_b_r <= hit_b ? data_r : '0;
    match_r <= (MY_IDX < cnt) && (data_r == value);
  end

  // commit: shift or swap
  always_comb begin
    data_nxt = data_r;
    if (ctrl.commit) begin
      unique case (ctrl.kind)
        REQ_INSERT: begin
          if (MY_IDX > idx_a) data_nxt = left_data;
          else if (hit_a) data_nxt = value;
        end
        REQ_DELETE: begin
          if (MY_IDX >= idx_a) data_nxt = right_data;
        end
        REQ_SWAP: begin
          if (hit_a) data_nxt = bus_b;
          else if (hit_b) data_nxt = bus_a;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign sel_a = sel_a_r;
  assign sel_b = sel_b_r;
  assign match = match_r;

endmodule

@@ src/ile_reduce.sv @@
// ile_reduce: collects the registered cell taps into the two read buses
// and encodes the first matching slot. Depends on ile_pkg.
module ile_reduce
  import ile_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 7
) (
  input  logic [DATA_W-1:0] sel_a [DEPTH],
  input  logic [DATA_W-1:0] sel_b [DEPTH],
  input  logic              match [DEPTH],
  output logic [DATA_W-1:0] bus_a,
  output logic [DATA_W-1:0] bus_b,
  output logic [IW-1:0]     first_idx,
  output logic              any_match
);

  // at most one cell drives each bus, so an OR merges them
  always_comb begin
    bus_a = '0;
    bus_b = '0;
    for (int i = 0; i < DEPTH; i++) begin
      bus_a = bus_a | sel_a[i];
      bus_b = bus_b | sel_b[i];
    end
  end

  // lowest matching slot wins
  always_comb begin
    first_idx = '0;
    any_match = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IW'(i);
        any_match = 1'b1;
      end
    end
  end

endmodule
